// File: sv/wkst_pkg.sv
// shared types and codes of the wait key slot table
package wkst_pkg;

    localparam int KEY_BITS = 81;

    typedef enum logic [1:0] {
        OP_ATTACH  = 2'd0,
        OP_DETACH  = 2'd1,
        OP_LOOKUP  = 2'd2,
        OP_REQUEUE = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        STS_OK        = 3'd0,
        STS_NOT_FOUND = 3'd1,
        STS_FULL      = 3'd2,
        STS_SAME_KEYS = 3'd3,
        STS_BAD       = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_READ,
        ST_DRAIN,
        ST_DECIDE,
        ST_WRITE_A,
        ST_WRITE_B,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic load;
        logic issue_scan;
        logic issue_det;
        logic decide;
        logic write_a;
        logic write_b;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic last_issue;
        logic out_free;
    } sts_t;

endpackage

// File: sv/wait_key_slot_table_unit.sv
// Wait key slot table: one operation at a time. Attach, lookup and requeue scan the slot
// memory one entry per cycle and then decide, write and return the result; detach reads its
// one slot. The single read port of the slot memory sets the scan length. The next word is
// taken the cycle after the result is loaded into the output register; a result still
// waiting in the output register holds the next one back.
module wait_key_slot_table_unit import wkst_pkg::*; #(
    parameter int SLOT_COUNT = 128,
    parameter int COUNT_BITS = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // key_process, key_address, key_shared, slot_index, dest_process, dest_address,
    // dest_shared, move_count, zero fill
    input  logic [191:0] s_tdata,
    // op
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // found, result_slot, result_waiters, dest_slot, slot_freed
    output logic [31:0]  m_tdata,
    // status
    output logic [2:0]   m_tuser
);

    cmd_t cmd;
    sts_t sts;

    wkst_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_op     (s_tuser),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    wkst_dp #(
        .SLOT_COUNT (SLOT_COUNT),
        .COUNT_BITS (COUNT_BITS)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .sts      (sts),
        .s_op     (s_tuser),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

// File: sv/wkst_ctrl.sv
// sequencer for one table operation: scan or read, decide, two writes, result
module wkst_ctrl import wkst_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    input  logic [1:0] s_op,
    output logic       s_tready,
    input  sts_t       sts,
    output cmd_t       cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = (op_t'(s_op) == OP_DETACH) ? ST_READ : ST_SCAN;
                end
            end
            ST_SCAN: begin
                cmd.issue_scan = 1'b1;
                if (sts.last_issue) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_READ: begin
                // read data of the detach slot is valid in the next cycle only
                cmd.issue_det = 1'b1;
                state_next    = ST_DECIDE;
            end
            ST_DRAIN: begin
                state_next = ST_DECIDE;
            end
            ST_DECIDE: begin
                cmd.decide = 1'b1;
                state_next = ST_WRITE_A;
            end
            ST_WRITE_A: begin
                cmd.write_a = 1'b1;
                state_next  = ST_WRITE_B;
            end
            ST_WRITE_B: begin
                cmd.write_b = 1'b1;
                state_next  = ST_DONE;
            end
            ST_DONE: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// File: sv/wkst_dp.sv
// slot memory, active bits, scan match logic, decision and result register
module wkst_dp import wkst_pkg::*; #(
    parameter int SLOT_COUNT = 128,
    parameter int COUNT_BITS = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  cmd_t         cmd,
    output sts_t         sts,
    input  logic [1:0]   s_op,
    input  logic [191:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [31:0]  m_tdata,
    output logic [2:0]   m_tuser
);

    localparam int SB = (SLOT_COUNT > 2) ? $clog2(SLOT_COUNT) : 1;
    localparam int CW = COUNT_BITS;
    localparam int SW = ((CW > 16) ? CW : 16) + 1;
    localparam int IW = ((SB > 7) ? SB : 7) + 1;
    localparam int EW = KEY_BITS + CW;
    localparam logic [SW-1:0] CMAX = SW'({CW{1'b1}});

    // input word registers
    op_t                  op_reg;
    logic [KEY_BITS-1:0]  pkey_reg, dkey_reg;
    logic [6:0]           sidx_reg;
    logic [15:0]          mv_reg;

    logic [EW-1:0]        mem [SLOT_COUNT];
    logic [SLOT_COUNT-1:0] act_vec_reg;

    logic [SB-1:0]        scan_cnt_reg;
    logic [SB-1:0]        rd_addr;
    logic [EW-1:0]        rd_data_reg;
    logic                 rd_act_reg;
    logic [SB-1:0]        rd_idx_reg;
    logic                 rd_valid_reg;

    logic                 pfound_reg, dfound_reg, ffound_reg;
    logic [SB-1:0]        pidx_reg, didx_reg, fidx_reg;
    logic [CW-1:0]        pcnt_reg, dcnt_reg;

    logic [IW-1:0]        sidx_ext;
    logic                 sidx_bad;
    logic [SB-1:0]        sidx_slot;

    // decision registers
    status_t              dec_status_reg, dec_status_next;
    logic                 dec_found_reg, dec_found_next;
    logic [SB-1:0]        dec_rslot_reg, dec_rslot_next;
    logic [CW-1:0]        dec_rwait_reg, dec_rwait_next;
    logic [SB-1:0]        dec_dslot_reg, dec_dslot_next;
    logic                 dec_freed_reg, dec_freed_next;
    logic                 wa_en_reg, wa_en_next, wb_en_reg, wb_en_next;
    logic [SB-1:0]        wa_addr_reg, wa_addr_next, wb_addr_reg, wb_addr_next;
    logic [EW-1:0]        wa_data_reg, wa_data_next, wb_data_reg, wb_data_next;
    logic                 wa_act_reg, wa_act_next, wb_act_reg, wb_act_next;

    logic                 m_tvalid_reg;
    logic [31:0]          m_tdata_reg;
    logic [2:0]           m_tuser_reg;

    assign sidx_ext  = IW'(sidx_reg);
    assign sidx_bad  = sidx_ext >= IW'(SLOT_COUNT);
    assign sidx_slot = sidx_ext[SB-1:0];
    assign rd_addr   = cmd.issue_det ? sidx_slot : scan_cnt_reg;

    assign sts.last_issue = scan_cnt_reg == SB'(SLOT_COUNT - 1);
    assign sts.out_free   = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg   <= op_t'(s_op);
            pkey_reg <= s_tdata[80:0];
            sidx_reg <= s_tdata[87:81];
            dkey_reg <= s_tdata[168:88];
            mv_reg   <= s_tdata[184:169];
        end
    end

    // slot memory with registered read
    always_ff @(posedge aclk) begin
        if (cmd.write_a && wa_en_reg) begin
            mem[wa_addr_reg] <= wa_data_reg;
        end else if (cmd.write_b && wb_en_reg) begin
            mem[wb_addr_reg] <= wb_data_reg;
        end
        rd_data_reg <= mem[rd_addr];
        rd_act_reg  <= act_vec_reg[rd_addr];
        rd_idx_reg  <= rd_addr;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            act_vec_reg  <= '0;
            scan_cnt_reg <= '0;
            rd_valid_reg <= 1'b0;
            pfound_reg   <= 1'b0;
            dfound_reg   <= 1'b0;
            ffound_reg   <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cmd.write_a && wa_en_reg) begin
                act_vec_reg[wa_addr_reg] <= wa_act_reg;
            end else if (cmd.write_b && wb_en_reg) begin
                act_vec_reg[wb_addr_reg] <= wb_act_reg;
            end
            rd_valid_reg <= cmd.issue_scan;
            if (cmd.load) begin
                scan_cnt_reg <= '0;
                pfound_reg   <= 1'b0;
                dfound_reg   <= 1'b0;
                ffound_reg   <= 1'b0;
            end else begin
                if (cmd.issue_scan) begin
                    scan_cnt_reg <= scan_cnt_reg + 1'b1;
                end
                if (rd_valid_reg) begin
                    // first active match for each key, lowest free slot
                    if (rd_act_reg && !pfound_reg
                        && rd_data_reg[EW-1:CW] == pkey_reg) begin
                        pfound_reg <= 1'b1;
                    end
                    if (rd_act_reg && !dfound_reg
                        && rd_data_reg[EW-1:CW] == dkey_reg) begin
                        dfound_reg <= 1'b1;
                    end
                    if (!rd_act_reg && !ffound_reg) begin
                        ffound_reg <= 1'b1;
                    end
                end
            end
            if (cmd.out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_valid_reg) begin
            if (rd_act_reg && !pfound_reg && rd_data_reg[EW-1:CW] == pkey_reg) begin
                pidx_reg <= rd_idx_reg;
                pcnt_reg <= rd_data_reg[CW-1:0];
            end
            if (rd_act_reg && !dfound_reg && rd_data_reg[EW-1:CW] == dkey_reg) begin
                didx_reg <= rd_idx_reg;
                dcnt_reg <= rd_data_reg[CW-1:0];
            end
            if (!rd_act_reg && !ffound_reg) begin
                fidx_reg <= rd_idx_reg;
            end
        end
    end

    always_comb begin
        logic [SW-1:0] base;
        logic [SW-1:0] upd;
        logic [SW-1:0] mvx;
        logic [SW-1:0] pcx;
        logic [SW-1:0] sum;
        logic [SW-1:0] rem;
        logic [SB-1:0] tslot;

        base = '0;
        upd  = '0;
        mvx  = SW'(mv_reg);
        pcx  = SW'(pcnt_reg);
        sum  = '0;
        rem  = pcx - mvx;
        tslot = dfound_reg ? didx_reg : fidx_reg;

        dec_status_next = STS_OK;
        dec_found_next  = 1'b0;
        dec_rslot_next  = '0;
        dec_rwait_next  = '0;
        dec_dslot_next  = '0;
        dec_freed_next  = 1'b0;
        wa_en_next      = 1'b0;
        wa_addr_next    = '0;
        wa_data_next    = '0;
        wa_act_next     = 1'b0;
        wb_en_next      = 1'b0;
        wb_addr_next    = '0;
        wb_data_next    = '0;
        wb_act_next     = 1'b0;

        case (op_reg)
            OP_ATTACH: begin
                dec_found_next = pfound_reg;
                if (!pfound_reg && !ffound_reg) begin
                    dec_status_next = STS_FULL;
                end else begin
                    base = pfound_reg ? pcx : '0;
                    if (base >= CMAX) begin
                        upd             = CMAX;
                        dec_status_next = STS_BAD;
                    end else begin
                        upd = base + 1'b1;
                    end
                    dec_rslot_next = pfound_reg ? pidx_reg : fidx_reg;
                    dec_rwait_next = upd[CW-1:0];
                    wa_en_next     = 1'b1;
                    wa_addr_next   = dec_rslot_next;
                    wa_data_next   = {pkey_reg, upd[CW-1:0]};
                    wa_act_next    = 1'b1;
                end
            end
            OP_DETACH: begin
                if (sidx_bad) begin
                    dec_status_next = STS_BAD;
                end else if (!rd_act_reg) begin
                    dec_status_next = STS_NOT_FOUND;
                    dec_rslot_next  = sidx_slot;
                end else begin
                    dec_found_next = 1'b1;
                    dec_rslot_next = sidx_slot;
                    if (rd_data_reg[CW-1:0] == '0) begin
                        dec_status_next = STS_BAD;
                    end else begin
                        dec_rwait_next = rd_data_reg[CW-1:0] - 1'b1;
                        dec_freed_next = dec_rwait_next == '0;
                        wa_en_next     = 1'b1;
                        wa_addr_next   = sidx_slot;
                        wa_data_next   = {rd_data_reg[EW-1:CW], dec_rwait_next};
                        wa_act_next    = !dec_freed_next;
                    end
                end
            end
            OP_LOOKUP: begin
                if (!pfound_reg) begin
                    dec_status_next = STS_NOT_FOUND;
                end else begin
                    dec_found_next = 1'b1;
                    dec_rslot_next = pidx_reg;
                    dec_rwait_next = pcnt_reg;
                end
            end
            default: begin
                if (pkey_reg == dkey_reg) begin
                    dec_status_next = STS_SAME_KEYS;
                end else if (!pfound_reg) begin
                    dec_status_next = STS_NOT_FOUND;
                end else begin
                    dec_found_next = 1'b1;
                    dec_rslot_next = pidx_reg;
                    dec_rwait_next = pcnt_reg;
                    if (mvx != '0) begin
                        if (mvx > pcx) begin
                            dec_status_next = STS_BAD;
                        end else if (!dfound_reg && !ffound_reg) begin
                            dec_status_next = STS_FULL;
                        end else begin
                            sum = (dfound_reg ? SW'(dcnt_reg) : '0) + mvx;
                            if (sum > CMAX) begin
                                sum             = CMAX;
                                dec_status_next = STS_BAD;
                            end
                            dec_rwait_next = rem[CW-1:0];
                            dec_freed_next = rem == '0;
                            dec_dslot_next = tslot;
                            wa_en_next     = 1'b1;
                            wa_addr_next   = tslot;
                            wa_data_next   = {dkey_reg, sum[CW-1:0]};
                            wa_act_next    = 1'b1;
                            wb_en_next     = 1'b1;
                            wb_addr_next   = pidx_reg;
                            wb_data_next   = {pkey_reg, rem[CW-1:0]};
                            wb_act_next    = !dec_freed_next;
                        end
                    end
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.decide) begin
            dec_status_reg <= dec_status_next;
            dec_found_reg  <= dec_found_next;
            dec_rslot_reg  <= dec_rslot_next;
            dec_rwait_reg  <= dec_rwait_next;
            dec_dslot_reg  <= dec_dslot_next;
            dec_freed_reg  <= dec_freed_next;
            wa_en_reg      <= wa_en_next;
            wa_addr_reg    <= wa_addr_next;
            wa_data_reg    <= wa_data_next;
            wa_act_reg     <= wa_act_next;
            wb_en_reg      <= wb_en_next;
            wb_addr_reg    <= wb_addr_next;
            wb_data_reg    <= wb_data_next;
            wb_act_reg     <= wb_act_next;
        end
        if (cmd.out_load) begin
            m_tuser_reg <= dec_status_reg;
            m_tdata_reg <= {dec_freed_reg, 7'(dec_dslot_reg), 16'(dec_rwait_reg),
                            7'(dec_rslot_reg), dec_found_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule
